@@ rtl/sec_pkg.sv @@
package sec_pkg;

    // pixel and field widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int ROW_OUT_W = 12;
    localparam int COL_OUT_W = 10;

    // apb port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_LSB    = 2;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_LOW_THRESHOLD  = 2'd1,
        REG_HIGH_THRESHOLD = 2'd2,
        REG_MID_THRESHOLD  = 2'd3
    } t_reg_idx;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST    = 11'd640;
    localparam logic [CFG_W-1:0] LOW_THRESHOLD_RST  = 11'd100;
    localparam logic [CFG_W-1:0] HIGH_THRESHOLD_RST = 11'd250;
    localparam logic [CFG_W-1:0] MID_THRESHOLD_RST  = 11'd150;

    localparam int MIN_WIDTH = 3;

    // grey = floor(sum / 3) as (sum * 683) >> 11, exact for sum <= 765
    localparam int SUM_W       = 10;
    localparam int GREY_PROD_W = 20;
    localparam int GREY_SHIFT  = 11;
    localparam logic [SUM_W-1:0] GREY_RECIP = 10'd683;

    // gradient arithmetic
    localparam int GRAD_W   = 11;
    localparam int ABS_W    = 10;
    localparam int SQ_W     = 20;
    localparam int MAG_W    = 21;
    localparam int THR_SQ_W = 22;

    // slope compare in 24 fraction bits
    localparam int TAN_FRAC  = 24;
    localparam int TAN_LO_W  = 23;
    localparam int TAN_HI_W  = 26;
    localparam int PROD_LO_W = ABS_W + TAN_LO_W;
    localparam int PROD_HI_W = ABS_W + TAN_HI_W;
    localparam logic [TAN_LO_W-1:0] TAN_LOW_Q24  = 23'd6949350;
    localparam logic [TAN_HI_W-1:0] TAN_HIGH_Q24 = 26'd40503782;

    typedef enum logic [1:0] {
        EDGE_NONE   = 2'd0,
        EDGE_WEAK   = 2'd1,
        EDGE_STRONG = 2'd2
    } t_edge_class;

    // output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    // window indexed [row][column], row 0 oldest line, column 0 leftmost
    typedef logic [2:0][2:0][PIX_W-1:0] t_window;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_start;
    } t_in_word;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] center_row;
        logic [COL_OUT_W-1:0] center_column;
        t_edge_class          edge_class;
        logic                 mid_edge;
        logic                 neighbor_brighter;
    } t_out_word;

    typedef struct packed {
        logic [CFG_W-1:0]    frame_width;
        logic [THR_SQ_W-1:0] low_sq;
        logic [THR_SQ_W-1:0] mid_sq;
        logic [THR_SQ_W-1:0] high_sq;
    } t_cfg;

    typedef struct packed {
        logic                 valid;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic                 interior;
    } t_meta;

endpackage

@@ rtl/sobel_edge_classifier.sv @@
// sobel edge classifier: rgb raster stream in, one classified word per pixel past the first row
// throughput: one pixel per cycle when not stalled; line stores read at accept, write back next cycle
// a window's word passes the line store read, the window, the gradient registers and the output queue
// up to 8 words queue while the output stalls, then the input stalls
// reset: synchronous active low, position at row 0 column 0, window zero, queue empty
// line stores are not cleared; unwritten entries only feed border words, which read as zero
module sobel_edge_classifier #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  sec_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output sec_pkg::t_out_word              o_out_word,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sec_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sec_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sec_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    // column counter indexes the line stores, width register can hold MAX_WIDTH itself
    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > sec_pkg::CFG_W) ? WW : sec_pkg::CFG_W;

    sec_pkg::t_cfg                       cfg;
    logic [CMPW-1:0]                     fw_ext;
    logic [WW-1:0]                       w_eff;

    logic                                accept;
    logic                                pop;
    logic [RW-1:0]                       r_row;
    logic [CW-1:0]                       r_col;
    logic [RW-1:0]                       cur_r;
    logic [CW-1:0]                       cur_c;
    logic [RW-1:0]                       n_row;
    logic [CW-1:0]                       n_col;
    logic                                produce;
    logic [RW-1:0]                       crow;
    logic [CW-1:0]                       ccol;
    logic                                interior;

    logic [sec_pkg::SUM_W-1:0]           pix_sum;
    logic [sec_pkg::GREY_PROD_W-1:0]     grey_prod;
    logic [sec_pkg::PIX_W-1:0]           grey;

    sec_pkg::t_meta                      r_b_meta;
    sec_pkg::t_meta                      r_c_meta;
    sec_pkg::t_window                    window;

    logic                                grad_push;
    sec_pkg::t_out_word                  grad_word;
    logic [sec_pkg::FIFO_CNT_W-1:0]      r_credit;

    // configuration port
    sec_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // effective row width, clamped to the legal range
    always_comb begin
        fw_ext = CMPW'(cfg.frame_width);
        if (fw_ext < CMPW'(sec_pkg::MIN_WIDTH)) begin
            w_eff = WW'(sec_pkg::MIN_WIDTH);
        end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(fw_ext);
        end
    end

    // input handshake: stall only on the word credit, never on valid
    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_credit >= sec_pkg::FIFO_CNT_W'(sec_pkg::FIFO_DEPTH));
    assign pop        = o_out_valid && !i_out_stall;

    // grey conversion by reciprocal multiply
    always_comb begin
        pix_sum   = sec_pkg::SUM_W'(i_in_word.red) + sec_pkg::SUM_W'(i_in_word.green)
                  + sec_pkg::SUM_W'(i_in_word.blue);
        grey_prod = sec_pkg::GREY_PROD_W'(pix_sum) * sec_pkg::GREY_PROD_W'(sec_pkg::GREY_RECIP);
        grey      = grey_prod[sec_pkg::GREY_SHIFT +: sec_pkg::PIX_W];
    end

    // raster position of the arriving pixel and of the pixel it completes
    always_comb begin
        cur_r = i_in_word.frame_start ? '0 : r_row;
        cur_c = i_in_word.frame_start ? '0 : r_col;

        // nothing on row 0, nor on the first pixel of row 1
        produce = (cur_r != '0) && !((cur_r == RW'(1)) && (cur_c == '0));

        // described pixel sits one row up, one column left; column 0 wraps to the end of the row two up
        if (cur_c != '0) begin
            crow = cur_r - 1'b1;
            ccol = cur_c - 1'b1;
        end else begin
            crow = cur_r - RW'(2);
            ccol = CW'(w_eff - 1'b1);
        end

        // border: top row, left column, right column
        interior = (crow != '0) && (ccol != '0)
                 && ((WW'(ccol) + 1'b1) < w_eff);

        // advance, a column at or past the last one ends the row
        if ((WW'(cur_c) + 1'b1) >= w_eff) begin
            n_col = '0;
            n_row = (cur_r != RW'(MAX_HEIGHT - 1)) ? cur_r + 1'b1 : cur_r;
        end else begin
            n_col = cur_c + 1'b1;
            n_row = cur_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row          <= '0;
            r_col          <= '0;
            r_b_meta.valid <= 1'b0;
            r_c_meta.valid <= 1'b0;
            r_credit       <= '0;
        end else begin
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            r_b_meta.valid <= accept && produce;
            r_c_meta.valid <= r_b_meta.valid;
            // one credit per word from accept until the consumer takes it
            r_credit <= r_credit + sec_pkg::FIFO_CNT_W'(accept && produce)
                      - sec_pkg::FIFO_CNT_W'(pop);
        end

        // word position rides along with the pixel through the line stores
        if (accept) begin
            r_b_meta.row      <= sec_pkg::ROW_OUT_W'(crow);
            r_b_meta.col      <= sec_pkg::COL_OUT_W'(ccol);
            r_b_meta.interior <= interior;
        end
        r_c_meta.row      <= r_b_meta.row;
        r_c_meta.col      <= r_b_meta.col;
        r_c_meta.interior <= r_b_meta.interior;
    end

    // line stores and 3x3 window: read at accept, write back and shift next cycle
    sec_line_window #(
        .DEPTH (MAX_WIDTH)
    ) u_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept),
        .i_rd_idx (cur_c),
        .i_grey   (grey),
        .o_window (window)
    );

    // sobel pair, magnitude and direction over three stages
    sec_gradient u_grad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_window (window),
        .i_meta   (r_c_meta),
        .i_cfg    (cfg),
        .o_push   (grad_push),
        .o_word   (grad_word)
    );

    // output queue parts the pipe from the consumer
    sec_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (grad_push),
        .i_word  (grad_word),
        .i_pop   (pop),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

endmodule

@@ rtl/sec_cfg_regs.sv @@
module sec_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sec_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sec_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sec_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output sec_pkg::t_cfg                   o_cfg
);

    logic [sec_pkg::CFG_W-1:0]    r_frame_width;
    logic [sec_pkg::CFG_W-1:0]    r_low;
    logic [sec_pkg::CFG_W-1:0]    r_high;
    logic [sec_pkg::CFG_W-1:0]    r_mid;
    logic [sec_pkg::THR_SQ_W-1:0] r_low_sq;
    logic [sec_pkg::THR_SQ_W-1:0] r_high_sq;
    logic [sec_pkg::THR_SQ_W-1:0] r_mid_sq;
    sec_pkg::t_reg_idx            reg_idx;
    logic                         wr_en;

    assign pready  = 1'b1;
    assign reg_idx = sec_pkg::t_reg_idx'(paddr[sec_pkg::REG_LSB +: 2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= sec_pkg::FRAME_WIDTH_RST;
            r_low         <= sec_pkg::LOW_THRESHOLD_RST;
            r_high        <= sec_pkg::HIGH_THRESHOLD_RST;
            r_mid         <= sec_pkg::MID_THRESHOLD_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                sec_pkg::REG_FRAME_WIDTH:    r_frame_width <= pwdata[sec_pkg::CFG_W-1:0];
                sec_pkg::REG_LOW_THRESHOLD:  r_low         <= pwdata[sec_pkg::CFG_W-1:0];
                sec_pkg::REG_HIGH_THRESHOLD: r_high        <= pwdata[sec_pkg::CFG_W-1:0];
                sec_pkg::REG_MID_THRESHOLD:  r_mid         <= pwdata[sec_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // squared thresholds, used only deep in the pipe
    always_ff @(posedge i_clk) begin
        r_low_sq  <= sec_pkg::THR_SQ_W'(r_low)  * sec_pkg::THR_SQ_W'(r_low);
        r_high_sq <= sec_pkg::THR_SQ_W'(r_high) * sec_pkg::THR_SQ_W'(r_high);
        r_mid_sq  <= sec_pkg::THR_SQ_W'(r_mid)  * sec_pkg::THR_SQ_W'(r_mid);
    end

    always_comb begin
        unique case (reg_idx)
            sec_pkg::REG_FRAME_WIDTH:    prdata = sec_pkg::APB_DATA_W'(r_frame_width);
            sec_pkg::REG_LOW_THRESHOLD:  prdata = sec_pkg::APB_DATA_W'(r_low);
            sec_pkg::REG_HIGH_THRESHOLD: prdata = sec_pkg::APB_DATA_W'(r_high);
            sec_pkg::REG_MID_THRESHOLD:  prdata = sec_pkg::APB_DATA_W'(r_mid);
            default:                     prdata = '0;
        endcase
    end

    assign o_cfg.frame_width = r_frame_width;
    assign o_cfg.low_sq      = r_low_sq;
    assign o_cfg.mid_sq      = r_mid_sq;
    assign o_cfg.high_sq     = r_high_sq;

endmodule

@@ rtl/sec_line_window.sv @@
module sec_line_window #(
    parameter  int DEPTH = 1024,
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [IW-1:0]              i_rd_idx,
    input  logic [sec_pkg::PIX_W-1:0]  i_grey,
    output sec_pkg::t_window           o_window
);

    logic [sec_pkg::PIX_W-1:0] mem_up  [DEPTH];
    logic [sec_pkg::PIX_W-1:0] mem_mid [DEPTH];

    logic                      r_b_valid;
    logic [IW-1:0]             r_b_idx;
    logic [sec_pkg::PIX_W-1:0] r_b_grey;
    logic [sec_pkg::PIX_W-1:0] r_up_q;
    logic [sec_pkg::PIX_W-1:0] r_mid_q;
    logic                      r_fwd;
    logic [sec_pkg::PIX_W-1:0] r_fwd_up;
    logic [sec_pkg::PIX_W-1:0] r_fwd_mid;
    logic [sec_pkg::PIX_W-1:0] up_eff;
    logic [sec_pkg::PIX_W-1:0] mid_eff;
    sec_pkg::t_window          r_win;
    sec_pkg::t_window          n_win;

    // read-during-write on the same entry returns what is being written
    assign up_eff  = r_fwd ? r_fwd_up  : r_up_q;
    assign mid_eff = r_fwd ? r_fwd_mid : r_mid_q;

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            mem_up[r_b_idx]  <= mid_eff;
            mem_mid[r_b_idx] <= r_b_grey;
        end
        if (i_rd_en) begin
            r_up_q    <= mem_up[i_rd_idx];
            r_mid_q   <= mem_mid[i_rd_idx];
            r_b_idx   <= i_rd_idx;
            r_b_grey  <= i_grey;
            r_fwd     <= r_b_valid && (r_b_idx == i_rd_idx);
            r_fwd_up  <= mid_eff;
            r_fwd_mid <= r_b_grey;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k][0] = r_win[k][1];
            n_win[k][1] = r_win[k][2];
        end
        n_win[0][2] = up_eff;
        n_win[1][2] = mid_eff;
        n_win[2][2] = r_b_grey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_win     <= '0;
        end else begin
            r_b_valid <= i_rd_en;
            if (r_b_valid) begin
                r_win <= n_win;
            end
        end
    end

    assign o_window = r_win;

endmodule

@@ rtl/sec_gradient.sv @@
module sec_gradient (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sec_pkg::t_window  i_window,
    input  sec_pkg::t_meta    i_meta,
    input  sec_pkg::t_cfg     i_cfg,
    output logic              o_push,
    output sec_pkg::t_out_word o_word
);

    typedef struct packed {
        logic h;
        logic d;
        logic v;
        logic a;
    } t_nbr;

    logic [sec_pkg::SUM_W-1:0]          top_sum, bot_sum, lft_sum, rgt_sum;
    logic signed [sec_pkg::GRAD_W-1:0]  n_gv, n_gh;
    t_nbr                               n_nbr;
    logic [sec_pkg::PIX_W-1:0]          cen;

    sec_pkg::t_meta                     r_s1_meta;
    logic signed [sec_pkg::GRAD_W-1:0]  r_gv, r_gh;
    t_nbr                               r_s1_nbr;

    logic [sec_pkg::ABS_W-1:0]          n_a, n_b;
    sec_pkg::t_meta                     r_s2_meta;
    t_nbr                               r_s2_nbr;
    logic [sec_pkg::ABS_W-1:0]          r_a;
    logic                               r_a_zero;
    logic                               r_neg;
    logic [sec_pkg::SQ_W-1:0]           r_a_sq, r_b_sq;
    logic [sec_pkg::PROD_LO_W-1:0]      r_b_lo;
    logic [sec_pkg::PROD_HI_W-1:0]      r_b_hi;

    logic [sec_pkg::MAG_W-1:0]          m2;
    logic [sec_pkg::PROD_HI_W-1:0]      a_shift;
    logic                               below_lo, below_hi, nbr;
    sec_pkg::t_edge_class               ec;

    // stage 1: sobel sums and neighbor compares from the window
    always_comb begin
        top_sum = sec_pkg::SUM_W'(i_window[0][0]) + (sec_pkg::SUM_W'(i_window[0][1]) << 1)
                + sec_pkg::SUM_W'(i_window[0][2]);
        bot_sum = sec_pkg::SUM_W'(i_window[2][0]) + (sec_pkg::SUM_W'(i_window[2][1]) << 1)
                + sec_pkg::SUM_W'(i_window[2][2]);
        lft_sum = sec_pkg::SUM_W'(i_window[0][0]) + (sec_pkg::SUM_W'(i_window[1][0]) << 1)
                + sec_pkg::SUM_W'(i_window[2][0]);
        rgt_sum = sec_pkg::SUM_W'(i_window[0][2]) + (sec_pkg::SUM_W'(i_window[1][2]) << 1)
                + sec_pkg::SUM_W'(i_window[2][2]);
        n_gv    = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
        n_gh    = $signed({1'b0, rgt_sum}) - $signed({1'b0, lft_sum});
        cen     = i_window[1][1];
        n_nbr.h = (i_window[1][2] > cen) || (i_window[1][0] > cen);
        n_nbr.d = (i_window[0][0] > cen) || (i_window[2][2] > cen);
        n_nbr.v = (i_window[0][1] > cen) || (i_window[2][1] > cen);
        n_nbr.a = (i_window[2][0] > cen) || (i_window[0][2] > cen);
    end

    // stage 2: magnitudes, squares and slope products
    always_comb begin
        n_a = r_gh[sec_pkg::GRAD_W-1] ? sec_pkg::ABS_W'(-r_gh) : sec_pkg::ABS_W'(r_gh);
        n_b = r_gv[sec_pkg::GRAD_W-1] ? sec_pkg::ABS_W'(-r_gv) : sec_pkg::ABS_W'(r_gv);
    end

    always_ff @(posedge i_clk) begin
        r_gv     <= n_gv;
        r_gh     <= n_gh;
        r_s1_nbr <= n_nbr;
        r_s1_meta.row      <= i_meta.row;
        r_s1_meta.col      <= i_meta.col;
        r_s1_meta.interior <= i_meta.interior;

        r_a      <= n_a;
        r_a_zero <= (r_gh == '0);
        r_neg    <= r_gh[sec_pkg::GRAD_W-1] ^ r_gv[sec_pkg::GRAD_W-1];
        r_a_sq   <= sec_pkg::SQ_W'(n_a) * sec_pkg::SQ_W'(n_a);
        r_b_sq   <= sec_pkg::SQ_W'(n_b) * sec_pkg::SQ_W'(n_b);
        r_b_lo   <= sec_pkg::PROD_LO_W'(n_b) * sec_pkg::PROD_LO_W'(sec_pkg::TAN_LOW_Q24);
        r_b_hi   <= sec_pkg::PROD_HI_W'(n_b) * sec_pkg::PROD_HI_W'(sec_pkg::TAN_HIGH_Q24);
        r_s2_nbr <= r_s1_nbr;
        r_s2_meta.row      <= r_s1_meta.row;
        r_s2_meta.col      <= r_s1_meta.col;
        r_s2_meta.interior <= r_s1_meta.interior;

        if (!i_rst_n) begin
            r_s1_meta.valid <= 1'b0;
            r_s2_meta.valid <= 1'b0;
        end else begin
            r_s1_meta.valid <= i_meta.valid;
            r_s2_meta.valid <= r_s1_meta.valid;
        end
    end

    // stage 3: threshold compares and direction pick
    always_comb begin
        m2       = sec_pkg::MAG_W'(r_a_sq) + sec_pkg::MAG_W'(r_b_sq);
        a_shift  = sec_pkg::PROD_HI_W'(r_a) << sec_pkg::TAN_FRAC;
        below_lo = a_shift < sec_pkg::PROD_HI_W'(r_b_lo);
        below_hi = a_shift < r_b_hi;

        if (sec_pkg::THR_SQ_W'(m2) > i_cfg.high_sq) begin
            ec = sec_pkg::EDGE_STRONG;
        end else if (sec_pkg::THR_SQ_W'(m2) > i_cfg.low_sq) begin
            ec = sec_pkg::EDGE_WEAK;
        end else begin
            ec = sec_pkg::EDGE_NONE;
        end

        // zero horizontal gradient and near-vertical slopes share the vertical pair
        if (r_a_zero || below_lo) begin
            nbr = r_s2_nbr.v;
        end else if (below_hi) begin
            nbr = r_neg ? r_s2_nbr.d : r_s2_nbr.a;
        end else begin
            nbr = r_s2_nbr.h;
        end

        o_word.center_row    = r_s2_meta.row;
        o_word.center_column = r_s2_meta.col;
        if (r_s2_meta.interior) begin
            o_word.edge_class        = ec;
            o_word.mid_edge          = sec_pkg::THR_SQ_W'(m2) > i_cfg.mid_sq;
            o_word.neighbor_brighter = nbr;
        end else begin
            o_word.edge_class        = sec_pkg::EDGE_NONE;
            o_word.mid_edge          = 1'b0;
            o_word.neighbor_brighter = 1'b0;
        end
    end

    assign o_push = r_s2_meta.valid;

endmodule

@@ rtl/sec_out_fifo.sv @@
module sec_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sec_pkg::t_out_word i_word,
    input  logic               i_pop,
    output logic               o_valid,
    output sec_pkg::t_out_word o_word
);

    sec_pkg::t_out_word              r_mem [sec_pkg::FIFO_DEPTH];
    logic [sec_pkg::FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [sec_pkg::FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [sec_pkg::FIFO_CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + sec_pkg::FIFO_CNT_W'(i_push) - sec_pkg::FIFO_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

endmodule

@@ rtl/sec_checker.sv @@
module sec_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input sec_pkg::t_out_word o_out_word
);

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    // a taken word always frees a credit for the next pixel
    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |=> !o_in_stall)
        else $error("input stalled right after a word was taken");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind sobel_edge_classifier sec_checker u_sec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

@@ sim/edge_class_checker.sv @@
`timescale 1ns / 100ps

module edge_class_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  sec_pkg::t_in_word              i_in_word,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  sec_pkg::t_out_word             i_out_word,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [sec_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [sec_pkg::APB_DATA_W-1:0] i_pwdata,
    input  logic [sec_pkg::APB_DATA_W-1:0] i_prdata,
    input  logic                           i_pready,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam int     LINE_DEPTH  = 1024;
    localparam int     ROW_CEILING = 4096;
    localparam longint SLOPE_LOW   = 64'd6949350;
    localparam longint SLOPE_HIGH  = 64'd40503782;

    logic [sec_pkg::CFG_W-1:0] width_reg;
    logic [sec_pkg::CFG_W-1:0] low_reg;
    logic [sec_pkg::CFG_W-1:0] high_reg;
    logic [sec_pkg::CFG_W-1:0] mid_reg;
    logic [sec_pkg::CFG_W-1:0] readback;

    logic [sec_pkg::PIX_W-1:0] upper_line [LINE_DEPTH];
    logic [sec_pkg::PIX_W-1:0] middle_line [LINE_DEPTH];
    logic [sec_pkg::PIX_W-1:0] win [0:2][0:2];
    int unsigned               row_pos;
    int unsigned               col_pos;

    sec_pkg::t_out_word expected_edge_words [$];
    sec_pkg::t_out_word oldest_word;
    int                 fail_total   = 0;
    int                 pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    initial begin
        for (int k = 0; k < LINE_DEPTH; k++) begin
            upper_line[k]  = '0;
            middle_line[k] = '0;
        end
    end

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_total++;
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, what, want, got);
        end
    endfunction

    // quantized gradient direction, -2..2
    function automatic int slope_direction(int gv, int gh);
        longint a;
        longint b;
        int     mag;
        a = (gh < 0) ? -gh : gh;
        b = (gv < 0) ? -gv : gv;
        if (a == 0) return 0;
        if (b == 0) mag = 2;
        else if ((a << 24) < b * SLOPE_LOW) mag = 0;
        else if ((a << 24) < b * SLOPE_HIGH) mag = 1;
        else mag = 2;
        if (b != 0 && ((gh < 0) != (gv < 0))) mag = -mag;
        if (b == 0 && gh < 0) mag = -mag;
        return mag;
    endfunction

    task automatic predict_edge_word(input sec_pkg::t_in_word px);
        int unsigned               w;
        int unsigned               grey;
        int unsigned               r;
        int unsigned               c;
        int unsigned               crow;
        int unsigned               ccol;
        int                        gv;
        int                        gh;
        int                        mag_sq;
        int                        dir;
        logic [sec_pkg::PIX_W-1:0] cen;
        sec_pkg::t_edge_class      ec;
        logic                      me;
        logic                      nbr;
        sec_pkg::t_out_word        word;

        w = width_reg;
        if (w < 3) w = 3;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        grey = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
        if (px.frame_start) begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;

        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = middle_line[c];
        win[2][2] = grey[sec_pkg::PIX_W-1:0];
        upper_line[c]  = middle_line[c];
        middle_line[c] = grey[sec_pkg::PIX_W-1:0];

        if (r >= 1 && !(r == 1 && c == 0)) begin
            ec  = sec_pkg::EDGE_NONE;
            me  = 1'b0;
            nbr = 1'b0;
            if (c >= 1) begin
                crow = r - 1;
                ccol = c - 1;
            end else begin
                crow = r - 2;
                ccol = w - 1;
            end
            if (crow >= 1 && ccol >= 1 && ccol + 1 < w) begin
                gv = int'(win[2][0]) - int'(win[0][0])
                   + 2 * (int'(win[2][1]) - int'(win[0][1]))
                   + int'(win[2][2]) - int'(win[0][2]);
                gh = int'(win[0][2]) - int'(win[0][0])
                   + 2 * (int'(win[1][2]) - int'(win[1][0]))
                   + int'(win[2][2]) - int'(win[2][0]);
                mag_sq = gv * gv + gh * gh;
                if (mag_sq > int'(high_reg) * int'(high_reg)) ec = sec_pkg::EDGE_STRONG;
                else if (mag_sq > int'(low_reg) * int'(low_reg)) ec = sec_pkg::EDGE_WEAK;
                me = (mag_sq > int'(mid_reg) * int'(mid_reg));
                dir = slope_direction(gv, gh);
                cen = win[1][1];
                case (dir)
                    -1:      nbr = (win[0][0] > cen) || (win[2][2] > cen);
                    0:       nbr = (win[0][1] > cen) || (win[2][1] > cen);
                    1:       nbr = (win[2][0] > cen) || (win[0][2] > cen);
                    default: nbr = (win[1][2] > cen) || (win[1][0] > cen);
                endcase
            end
            word.center_row        = sec_pkg::ROW_OUT_W'(crow);
            word.center_column     = sec_pkg::COL_OUT_W'(ccol);
            word.edge_class        = ec;
            word.mid_edge          = me;
            word.neighbor_brighter = nbr;
            expected_edge_words.insert(expected_edge_words.size(), word);
        end

        if (c + 1 >= w) begin
            col_pos = 0;
            if (row_pos + 1 < ROW_CEILING) row_pos++;
        end else begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg <= sec_pkg::FRAME_WIDTH_RST;
            low_reg   <= sec_pkg::LOW_THRESHOLD_RST;
            high_reg  <= sec_pkg::HIGH_THRESHOLD_RST;
            mid_reg   <= sec_pkg::MID_THRESHOLD_RST;
            row_pos   = 0;
            col_pos   = 0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) win[k][j] = '0;
            end
            expected_edge_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_edge_words.size() == 0) begin
                    fail_total++;
                    $display("%0t ns: unexpected word, expected none actual %h",
                             $time, i_out_word);
                end else begin
                    oldest_word = expected_edge_words.pop_front();
                    check_field("center_row", 32'(oldest_word.center_row),
                                32'(i_out_word.center_row));
                    check_field("center_column", 32'(oldest_word.center_column),
                                32'(i_out_word.center_column));
                    check_field("edge_class", 32'(oldest_word.edge_class),
                                32'(i_out_word.edge_class));
                    check_field("mid_edge", 32'(oldest_word.mid_edge),
                                32'(i_out_word.mid_edge));
                    check_field("neighbor_brighter", 32'(oldest_word.neighbor_brighter),
                                32'(i_out_word.neighbor_brighter));
                end
            end

            if (i_in_valid && !i_in_stall) predict_edge_word(i_in_word);

            if (i_psel && i_penable && i_pready) begin
                case (sec_pkg::t_reg_idx'(i_paddr[sec_pkg::APB_ADDR_W-1:sec_pkg::REG_LSB]))
                    sec_pkg::REG_FRAME_WIDTH:    readback = width_reg;
                    sec_pkg::REG_LOW_THRESHOLD:  readback = low_reg;
                    sec_pkg::REG_HIGH_THRESHOLD: readback = high_reg;
                    default:                     readback = mid_reg;
                endcase
                if (i_pwrite) begin
                    case (sec_pkg::t_reg_idx'(i_paddr[sec_pkg::APB_ADDR_W-1:sec_pkg::REG_LSB]))
                        sec_pkg::REG_FRAME_WIDTH:    width_reg <= i_pwdata[sec_pkg::CFG_W-1:0];
                        sec_pkg::REG_LOW_THRESHOLD:  low_reg   <= i_pwdata[sec_pkg::CFG_W-1:0];
                        sec_pkg::REG_HIGH_THRESHOLD: high_reg  <= i_pwdata[sec_pkg::CFG_W-1:0];
                        default:                     mid_reg   <= i_pwdata[sec_pkg::CFG_W-1:0];
                    endcase
                end else begin
                    check_field("prdata", 32'(readback), i_prdata);
                end
            end
        end
        pending_total = expected_edge_words.size();
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 12;      // lets the pipeline empty, with margin
    localparam int HOLD_CYCLES   = 300;     // long output hold-off to fill the queue
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 85;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    sec_pkg::t_in_word              in_word = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    sec_pkg::t_out_word             out_word;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [sec_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [sec_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [sec_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    int   fail_count;
    int   pending_words;
    int   cycle_count = 0;
    int   src_idle_pct = 0;
    int   sink_stall_pct = 0;
    logic hold_req = 1'b0;
    int   hold_left = 0;
    int   cur_width = 640;

    // idle mix per phase: none, sender only, receiver only, both
    int src_modes  [4] = '{0, 74, 0, 30};
    int sink_modes [4] = '{0, 0, 74, 30};
    sec_pkg::t_reg_idx reg_order [4] = '{sec_pkg::REG_FRAME_WIDTH,
                                         sec_pkg::REG_LOW_THRESHOLD,
                                         sec_pkg::REG_HIGH_THRESHOLD,
                                         sec_pkg::REG_MID_THRESHOLD};

    sobel_edge_classifier dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    edge_class_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver side: random stall, plus a long hold-off when requested
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            out_stall <= 1'b0;
        end else begin
            if (hold_req) hold_left <= HOLD_CYCLES;
            else if (hold_left != 0) hold_left <= hold_left - 1;
            out_stall <= hold_req || (hold_left != 0)
                      || ($urandom_range(99) < sink_stall_pct);
        end
    end

    // one apb transfer, setup then access; psel is left high for back-to-back use
    task automatic apb_access(input logic write, input sec_pkg::t_reg_idx idx,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= sec_pkg::APB_ADDR_W'(idx) << sec_pkg::REG_LSB;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    // write all four registers, each followed by a read back
    task automatic configure(input logic [31:0] width_val, input logic [31:0] low_val,
                             input logic [31:0] high_val, input logic [31:0] mid_val);
        logic [31:0] vals [4];
        vals[0] = width_val;
        vals[1] = low_val;
        vals[2] = high_val;
        vals[3] = mid_val;
        for (int k = 0; k < 4; k++) begin
            apb_access(1'b1, reg_order[k], vals[k]);
            apb_access(1'b0, reg_order[k], 32'd0);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_width = int'(width_val[sec_pkg::CFG_W-1:0]);
        if (cur_width < sec_pkg::MIN_WIDTH) cur_width = sec_pkg::MIN_WIDTH;
        if (cur_width > 1024) cur_width = 1024;
    endtask

    // offer one pixel word, with random sender gaps before it
    task automatic offer_pixel(input sec_pkg::t_in_word px);
        int gap;
        gap = 0;
        while (src_idle_pct > 0 && gap < 40 && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= px;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // stop sending and wait until every expected word is out and the pipe is empty
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_words != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_threshold();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 2047;
            2:       return $urandom_range(2047);
            default: return $urandom_range(300);
        endcase
    endfunction

    // pixel content: noise, smooth ramps, checkerboard blocks, slanted steps
    function automatic sec_pkg::t_in_word make_pixel(int style, int base, int sr, int sc,
                                                     int r, int c);
        sec_pkg::t_in_word px;
        int                level;
        px = '0;
        case (style)
            0: begin
                px.red   = sec_pkg::PIX_W'($urandom);
                px.green = sec_pkg::PIX_W'($urandom);
                px.blue  = sec_pkg::PIX_W'($urandom);
                return px;
            end
            1: begin
                level = base + sr * r + sc * c + int'($urandom_range(6)) - 3;
                if (level < 0) level = 0;
                if (level > 255) level = 255;
            end
            2: level = (((r / 2) + (c / 3) + base) % 2 != 0) ? 255 : 0;
            default: level = (sr * r + sc * c + base - 128 >= 0) ? 200 : 40;
        endcase
        px.red   = sec_pkg::PIX_W'(level);
        px.green = sec_pkg::PIX_W'(level);
        px.blue  = sec_pkg::PIX_W'(level);
        return px;
    endfunction

    // frames of random height; noisy runs cut frames short and restart at random
    task automatic send_frames(input int min_rows, input int max_rows, input int budget,
                               input bit fresh, input bit noisy);
        int                sent;
        int                rows;
        int                limit;
        int                style;
        int                base;
        int                sr;
        int                sc;
        bit                first;
        sec_pkg::t_in_word px;
        sent  = 0;
        first = 1'b1;
        while (sent < budget) begin
            rows  = $urandom_range(min_rows, max_rows);
            limit = rows * cur_width;
            if (noisy && $urandom_range(7) == 0) limit = $urandom_range(1, limit);
            style = $urandom_range(3);
            base  = $urandom_range(255);
            sr    = int'($urandom_range(40)) - 20;
            sc    = int'($urandom_range(40)) - 20;
            for (int k = 0; k < limit && sent < budget; k++) begin
                px = make_pixel(style, base, sr, sc, k / cur_width, k % cur_width);
                px.frame_start = (k == 0 && (fresh || !first))
                              || (noisy && $urandom_range(499) == 0);
                offer_pixel(px);
                sent++;
            end
            first = 1'b0;
        end
    endtask

    initial begin : stimulus
        sec_pkg::t_in_word px;
        int                wait_cycles;
        bit                leftover;
        logic [31:0]       width_val;

        leftover = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset values read back
        foreach (reg_order[k]) apb_access(1'b0, reg_order[k], 32'd0);
        psel    <= 1'b0;
        penable <= 1'b0;

        // directed: width 0 clamps to 3, three tiny frames
        //   uniform color -> zero gradient
        //   dark left, white right -> pure horizontal difference, vertical gradient zero
        //   white top, cyan middle, blue bottom -> pure vertical difference
        configure(32'd0, 32'd10, 32'd200, 32'd100);
        for (int f = 0; f < 3; f++) begin
            for (int k = 0; k < 9; k++) begin
                px = '0;
                case (f)
                    0: px.red = 8'hFF;
                    1: if (k % 3 == 2) px = '{8'hFF, 8'hFF, 8'hFF, 1'b0};
                    default: begin
                        if (k / 3 == 0) px = '{8'hFF, 8'hFF, 8'hFF, 1'b0};
                        if (k / 3 == 1) px = '{8'h00, 8'hFF, 8'hFF, 1'b0};
                        if (k / 3 == 2) px = '{8'h00, 8'h00, 8'hFF, 1'b0};
                    end
                endcase
                px.frame_start = (k == 0);
                offer_pixel(px);
            end
        end
        drain();

        // random phases over the idle mixes, narrow widths, assorted thresholds
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(5))
                0:       width_val = $urandom_range(2);
                1:       width_val = 3;
                2:       width_val = $urandom_range(4, 8);
                default: width_val = $urandom_range(9, 24);
            endcase
            // junk above the register width must be dropped
            if ($urandom_range(3) == 0) width_val = width_val | ($urandom & 32'hFFFF_F800);
            configure(width_val, pick_threshold(), pick_threshold(), pick_threshold());
            src_idle_pct = src_modes[p % 4];
            sink_stall_pct <= sink_modes[p % 4];
            send_frames(3, 7, PHASE_ITEMS, 1'b1, 1'b1);
            drain();
        end

        // back pressure: receiver holds off while the sender keeps offering
        configure(32'd12, 32'd60, 32'd180, 32'd120);
        src_idle_pct = 0;
        sink_stall_pct <= 0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        send_frames(8, 8, 200, 1'b1, 1'b0);
        drain();

        // width shrinks mid-row: stop inside row 2 of a 20 wide frame, go on at width 8
        configure(32'd20, 32'd40, 32'd150, 32'd90);
        src_idle_pct = 30;
        sink_stall_pct <= 30;
        send_frames(5, 5, 2 * 20 + 15, 1'b1, 1'b0);
        drain();
        configure(32'd8, 32'd40, 32'd150, 32'd90);
        send_frames(5, 5, 40, 1'b0, 1'b0);

        // end of run: no stall, wait out the expected words and the pipe
        in_valid <= 1'b0;
        sink_stall_pct <= 0;
        wait_cycles = 0;
        @(negedge clk);
        while (pending_words != 0 && wait_cycles < 4000) begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_words != 0) begin
            leftover = 1'b1;
            $display("%0t ns: %0d expected words never arrived", $time, pending_words);
        end

        if (fail_count == 0 && !leftover) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/sec_pkg.sv
rtl/sec_cfg_regs.sv
rtl/sec_line_window.sv
rtl/sec_gradient.sv
rtl/sec_out_fifo.sv
rtl/sobel_edge_classifier.sv
rtl/sec_checker.sv
sim/edge_class_checker.sv
sim/testbench.sv
